// ----- src/delimiter_field_splitter_assert.svh -----
// assertion macros used by the checker file
`ifndef DELIMITER_FIELD_SPLITTER_ASSERT_SVH
`define DELIMITER_FIELD_SPLITTER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define DFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dfs check failed");

// next-cycle implication, disabled while reset is low
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dfs check failed");

`endif

// ----- src/dfs_pkg.sv -----
package dfs_pkg;

    localparam int SEP_MAX_DEF    = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int BYTE_W       = 8;
    localparam int SEP_BYTES_W  = 64;
    localparam int SEP_LEN_W    = 4;
    localparam int MAX_FIELDS_W = 16;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [SEP_BYTES_W-1:0]  SEP_BYTES_RST  = 64'd44;
    localparam logic [SEP_LEN_W-1:0]    SEP_LEN_RST    = 4'd1;
    localparam logic [MAX_FIELDS_W-1:0] MAX_FIELDS_RST = 16'hFFFF;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index REG_SEP_BYTES  = 2'd0;
    localparam t_cfg_index REG_SEP_LEN    = 2'd1;
    localparam t_cfg_index REG_MAX_FIELDS = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tail;       // new byte lands in this cell
        logic     next_tail;  // new byte lands in the right neighbor
        logic     active;     // cell holds a pending byte
    } t_cell_ctl;

    typedef struct packed {
        t_byte in_byte;
        logic  end_of_string;
    } t_in_item;

    typedef struct packed {
        t_byte out_char;
        logic  char_valid;
        logic  field_end;
        logic  string_end;
        logic  run_last;
    } t_out_item;

endpackage

// ----- src/dfs_stream_if.sv -----
interface dfs_stream_if #(
    parameter type t_payload = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/dfs_window_cell.sv -----
module dfs_window_cell
    import dfs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_byte     i_in_byte,
    input  t_byte     i_right_byte,
    input  t_byte     i_sep_byte,
    input  logic      i_match,
    output t_byte     o_byte,
    output logic      o_match,
    output logic      o_tail_eq
);

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        case (i_ctl.op)
            CELL_HOLD:   n_byte = r_byte;
            CELL_APPEND: n_byte = i_ctl.tail ? i_in_byte : r_byte;
            CELL_SHIFT:  n_byte = i_ctl.next_tail ? i_in_byte : i_right_byte;
            default:     n_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte    = r_byte;
    // match runs left to right; idle cells pass it on
    assign o_match   = i_match & (!i_ctl.active | (r_byte == i_sep_byte));
    assign o_tail_eq = i_ctl.tail & (i_in_byte == i_sep_byte);

endmodule

// ----- src/dfs_out_buffer.sv -----
module dfs_out_buffer
    import dfs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    input  t_out_item           i_push_data,
    output logic                o_space,
    dfs_stream_if.source        o_out
);

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      r_skid_valid;
    t_out_item r_skid_data;
    logic      take;

    assign take    = r_out_valid & o_out.ready;
    // a push is only offered while the skid entry is free
    assign o_space = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= i_push_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= i_push_data;
            end
        end else if (take) begin
            r_out_valid  <= r_skid_valid;
            r_out_data   <= r_skid_data;
            r_skid_valid <= 1'b0;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_data;

endmodule

// ----- src/delimiter_field_splitter.sv -----
// channel   dir   payload                                             handshake
// i_in      in    in_byte, end_of_string                              valid/ready
// o_out     out   out_char, char_valid, field_end, string_end,        valid/ready
//                 run_last
// i_cfg     in    i_cfg_wr_en, i_cfg_index, i_cfg_wdata               write only
//
// one byte is taken per cycle while the input is not stalled; a byte that does
// not end the string gives at most one result, which goes straight into the
// two-entry output buffer; the last byte of a string adds a flush: the row of
// window cells shifts out one pending byte a cycle while the buffer has space,
// then the field-end or the empty result that closes the string
// synchronous active-low reset clears control state and the registers
// the input stalls during a flush and while the skid entry of the output buffer is full
module delimiter_field_splitter
    import dfs_pkg::*;
#(
    parameter int SEP_MAX    = SEP_MAX_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    dfs_stream_if.sink             i_in,
    dfs_stream_if.source           o_out,
    input  logic                   i_cfg_wr_en,
    input  t_cfg_index             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int LEN_W = $clog2(SEP_MAX + 1);
    localparam int CMP_W = (COUNT_BITS > MAX_FIELDS_W) ? COUNT_BITS : MAX_FIELDS_W;

    // configuration registers
    logic [SEP_BYTES_W-1:0]  r_sep_bytes;
    logic [SEP_LEN_W-1:0]    r_sep_len;
    logic [MAX_FIELDS_W-1:0] r_max_fields;

    // string state
    logic [LEN_W-1:0]      r_fill, n_fill;
    logic                  r_has, n_has;
    logic [COUNT_BITS-1:0] r_fields, n_fields;
    logic                  r_flush, n_flush;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] fill_old;
    logic             full;
    logic             pass;
    logic             match;
    logic             in_ready;
    logic             in_accept;
    logic             push_space;
    logic             push_valid;
    t_out_item        push_data;
    t_out_item        r0;
    logic             r0_valid;
    t_cell_op         cell_op;
    t_in_item         in_item;
    logic             restart;

    t_byte           cell_byte [SEP_MAX];
    logic [SEP_MAX:0] match_chain;
    logic [SEP_MAX-1:0] tail_eq;

    assign in_item = i_in.payload;

    // separator length 0 acts as 1, above SEP_MAX acts as SEP_MAX
    always_comb begin
        if (r_sep_len == '0) begin
            len = LEN_W'(1);
        end else if (r_sep_len > SEP_LEN_W'(SEP_MAX)) begin
            len = LEN_W'(SEP_MAX);
        end else begin
            len = LEN_W'(r_sep_len);
        end
    end

    assign fill_old = (r_fill >= len) ? (len - LEN_W'(1)) : r_fill;
    // the window is complete once the new byte is added
    assign full     = (fill_old == (len - LEN_W'(1)));
    // after max_fields fields, once a char is out, no more splitting
    assign pass     = (CMP_W'(r_fields) >= CMP_W'(r_max_fields)) && r_has;
    // pending bytes compare in their cells, the new byte at the tail cell
    assign match    = match_chain[SEP_MAX] & (|tail_eq);

    // row of window cells, oldest pending byte in cell 0
    assign match_chain[0] = 1'b1;
    for (genvar gi = 0; gi < SEP_MAX; gi++) begin : g_cell
        t_cell_ctl ctl;
        t_byte     right;

        assign ctl.op        = cell_op;
        assign ctl.tail      = !r_flush && (fill_old == LEN_W'(gi));
        assign ctl.next_tail = !r_flush && (fill_old == LEN_W'(gi + 1));
        assign ctl.active    = (LEN_W'(gi) < fill_old);

        if (gi == SEP_MAX - 1) begin : g_last
            assign right = in_item.in_byte;
        end else begin : g_mid
            assign right = cell_byte[gi + 1];
        end

        dfs_window_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_in_byte    (in_item.in_byte),
            .i_right_byte (right),
            .i_sep_byte   (r_sep_bytes[BYTE_W*gi +: BYTE_W]),
            .i_match      (match_chain[gi]),
            .o_byte       (cell_byte[gi]),
            .o_match      (match_chain[gi + 1]),
            .o_tail_eq    (tail_eq[gi])
        );
    end

    assign in_ready   = !r_flush && push_space;
    assign in_accept  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // separator rewrite restarts the string
    assign restart = i_cfg_wr_en &&
                     ((i_cfg_index == REG_SEP_BYTES) || (i_cfg_index == REG_SEP_LEN));

    always_comb begin
        n_fill     = r_fill;
        n_has      = r_has;
        n_fields   = r_fields;
        n_flush    = r_flush;
        cell_op    = CELL_HOLD;
        r0_valid   = 1'b0;
        r0         = '0;
        push_valid = 1'b0;
        push_data  = '0;

        if (r_flush) begin
            // end-of-string flush, one result a cycle while the buffer has space
            if (push_space) begin
                push_valid = 1'b1;
                if (r_fill != '0) begin
                    push_data.out_char   = cell_byte[0];
                    push_data.char_valid = 1'b1;
                    cell_op              = CELL_SHIFT;
                    n_fill               = r_fill - LEN_W'(1);
                    n_has                = 1'b1;
                end else begin
                    // field-end, or the empty result for an all-separator string
                    push_data.field_end  = r_has;
                    push_data.string_end = 1'b1;
                    push_data.run_last   = 1'b1;
                    n_fill               = '0;
                    n_has                = 1'b0;
                    n_fields             = '0;
                    n_flush              = 1'b0;
                end
            end
        end else if (in_accept) begin
            if (full && !pass && match) begin
                // separator found: close the field if it has chars
                n_fill = '0;
                if (r_has) begin
                    r0_valid     = 1'b1;
                    r0.field_end = 1'b1;
                    n_has        = 1'b0;
                    if (r_fields != '1) begin
                        n_fields = r_fields + COUNT_BITS'(1);
                    end
                end
            end else if (full) begin
                // oldest byte cannot start a separator: send it
                r0_valid      = 1'b1;
                r0.out_char   = (fill_old == '0) ? in_item.in_byte : cell_byte[0];
                r0.char_valid = 1'b1;
                n_has         = 1'b1;
                cell_op       = CELL_SHIFT;
                n_fill        = fill_old;
            end else begin
                cell_op = CELL_APPEND;
                n_fill  = fill_old + LEN_W'(1);
            end

            if (in_item.end_of_string) begin
                if ((n_fill != '0) || n_has || !r0_valid) begin
                    n_flush = 1'b1;
                end else begin
                    r0.string_end = 1'b1;
                    r0.run_last   = 1'b1;
                    n_fill        = '0;
                    n_has         = 1'b0;
                    n_fields      = '0;
                end
            end else begin
                r0.run_last = 1'b1;
            end

            push_valid = r0_valid;
            push_data  = r0;
        end

        if (restart) begin
            n_fill   = '0;
            n_has    = 1'b0;
            n_fields = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_bytes  <= SEP_BYTES_RST;
            r_sep_len    <= SEP_LEN_RST;
            r_max_fields <= MAX_FIELDS_RST;
            r_fill       <= '0;
            r_has        <= 1'b0;
            r_fields     <= '0;
            r_flush      <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_has    <= n_has;
            r_fields <= n_fields;
            r_flush  <= n_flush;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SEP_BYTES:  r_sep_bytes  <= i_cfg_wdata[SEP_BYTES_W-1:0];
                    REG_SEP_LEN:    r_sep_len    <= i_cfg_wdata[SEP_LEN_W-1:0];
                    REG_MAX_FIELDS: r_max_fields <= i_cfg_wdata[MAX_FIELDS_W-1:0];
                    default: begin
                        // unknown index, ignored
                    end
                endcase
            end
        end
    end

    // output register plus skid entry
    dfs_out_buffer u_out_buffer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_space      (push_space),
        .o_out        (o_out)
    );

endmodule

// ----- src/dfs_checker.sv -----
`include "delimiter_field_splitter_assert.svh"

module dfs_checker
    import dfs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_payload
);

    // a stalled result holds
    `DFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_payload))

    // a result that is not the last of its byte belongs to a flush, input must wait
    `DFS_ASSERT_NOW(a_flush_blocks_in, i_clk, i_rst_n,
        i_out_valid && !i_out_payload.run_last,
        !i_in_ready)

    // the empty result only closes a string
    `DFS_ASSERT_NOW(a_empty_is_end, i_clk, i_rst_n,
        i_out_valid && !i_out_payload.char_valid && !i_out_payload.field_end,
        i_out_payload.string_end && i_out_payload.run_last)

    // end of string is always the last result of its byte
    `DFS_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n,
        i_out_valid && i_out_payload.string_end,
        i_out_payload.run_last)

endmodule

bind delimiter_field_splitter dfs_checker u_dfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

// ----- test/tb_delimiter_field_splitter.sv -----
`default_nettype none

module tb_delimiter_field_splitter;
    import dfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEP_MAX     = SEP_MAX_DEF;
    localparam int COUNT_BITS  = COUNT_BITS_DEF;
    // room after the results for a flush still passing through the output buffer
    localparam int FLUSH_CYCLES = SEP_MAX + 4;
    // cycles with no request moving on either side before the run is abandoned
    localparam int IDLE_LIMIT  = 5000;
    // the long receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_ITEMS = 300;

    // index with no register behind it, must be ignored
    localparam t_cfg_index REG_NONE = 2'd3;

    typedef enum logic {
        SINK_OPEN,
        SINK_PATTERN
    } t_sink_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    t_cfg_index            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dfs_stream_if #(.t_payload(t_in_item))  in_if ();
    dfs_stream_if #(.t_payload(t_out_item)) out_if ();

    delimiter_field_splitter #(
        .SEP_MAX    (SEP_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // splitter model state, updated on every accepted request
    // ------------------------------------------------------------------
    logic [63:0]           sep_pattern;
    logic [3:0]            sep_len_reg;
    logic [15:0]           field_limit;
    t_byte                 win_bytes [SEP_MAX];
    int unsigned           win_fill;
    logic                  field_open;
    logic [COUNT_BITS-1:0] fields_done;

    // results still owed by the block, oldest first
    t_out_item pending_rows [$];

    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned hold_requests;
    int unsigned quiet_cycles;
    t_sink_mode  sink_mode;

    function automatic int unsigned active_sep_len();
        if (sep_len_reg == 0) return 1;
        if (sep_len_reg > SEP_MAX) return SEP_MAX;
        return 32'(sep_len_reg);
    endfunction

    function automatic void restart_string();
        win_fill    = 0;
        field_open  = 1'b0;
        fields_done = '0;
    endfunction

    function automatic t_out_item make_row(input t_byte ch, input logic cv, input logic fe);
        t_out_item row;
        row.out_char   = ch;
        row.char_valid = cv;
        row.field_end  = fe;
        row.string_end = 1'b0;
        row.run_last   = 1'b0;
        return row;
    endfunction

    // one byte through the splitter: queue up every result it causes
    function automatic void split_byte(input t_byte b, input logic eos);
        t_out_item   rows [$];
        int unsigned len;
        int unsigned k;
        bit          sep_hit;
        len = active_sep_len();
        if (win_fill >= len) win_fill = len - 1;
        win_bytes[win_fill] = b;
        win_fill++;

        if (win_fill == len) begin
            // once the field budget is spent an open field swallows separators
            sep_hit = !((fields_done >= field_limit) && field_open);
            for (k = 0; k < len; k++) begin
                if (win_bytes[k] != sep_pattern[8*k +: 8]) sep_hit = 0;
            end
            if (sep_hit) begin
                // empty fields are never closed
                if (field_open) begin
                    rows.push_back(make_row('0, 1'b0, 1'b1));
                    if (fields_done != '1) fields_done++;
                    field_open = 1'b0;
                end
                win_fill = 0;
            end else begin
                rows.push_back(make_row(win_bytes[0], 1'b1, 1'b0));
                field_open = 1'b1;
                for (k = 1; k < win_fill; k++) win_bytes[k-1] = win_bytes[k];
                win_fill--;
            end
        end

        if (eos) begin
            // flush the window, close the field, or mark an empty string
            for (k = 0; k < win_fill; k++) begin
                rows.push_back(make_row(win_bytes[k], 1'b1, 1'b0));
                field_open = 1'b1;
            end
            if (field_open) rows.push_back(make_row('0, 1'b0, 1'b1));
            if (rows.size() == 0) rows.push_back(make_row('0, 1'b0, 1'b0));
            rows[rows.size()-1].string_end = 1'b1;
            restart_string();
        end

        if (rows.size() != 0) rows[rows.size()-1].run_last = 1'b1;
        foreach (rows[i]) pending_rows.push_back(rows[i]);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 30)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // each accepted result against the oldest pending one
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (pending_rows.size() == 0) begin
                report_mismatch("result with nothing pending", int'(got), 0);
            end else begin
                want = pending_rows.pop_front();
                if (got.out_char !== want.out_char)
                    report_mismatch("out_char", int'(got.out_char), int'(want.out_char));
                if (got.char_valid !== want.char_valid)
                    report_mismatch("char_valid", int'(got.char_valid),
                                    int'(want.char_valid));
                if (got.field_end !== want.field_end)
                    report_mismatch("field_end", int'(got.field_end), int'(want.field_end));
                if (got.string_end !== want.string_end)
                    report_mismatch("string_end", int'(got.string_end),
                                    int'(want.string_end));
                if (got.run_last !== want.run_last)
                    report_mismatch("run_last", int'(got.run_last), int'(want.run_last));
            end
        end
    end

    // watchdog: nothing moving for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: open, or stalling on a rotating pattern, plus long hold-offs
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        int unsigned holds_served;
        int unsigned pat_age;
        logic [15:0] stall_pat;
        hold_left    = 0;
        holds_served = 0;
        pat_age      = 0;
        stall_pat    = '1;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left    = HOLD_CYCLES - 1;
                out_if.ready = 1'b0;
            end else if (sink_mode == SINK_OPEN) begin
                out_if.ready = 1'b1;
            end else begin
                if (pat_age == 0) begin
                    // pick a new pattern: light, heavy or no stalls
                    case ($urandom_range(0, 3))
                        0: stall_pat = '1;
                        1: stall_pat = 16'($urandom & $urandom);
                        default: stall_pat = 16'($urandom | $urandom);
                    endcase
                    pat_age = 16;
                end
                out_if.ready = stall_pat[0];
                stall_pat    = {stall_pat[0], stall_pat[15:1]};
                pat_age--;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // bursts of random length with random gaps, long bursts now and then
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    // offer one request, wait for it to be taken; valid stays up for the next
    task automatic send_byte(input t_byte b, input logic eos);
        in_if.payload.in_byte       = b;
        in_if.payload.end_of_string = eos;
        in_if.valid                 = 1'b1;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        split_byte(b, eos);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_bytes(input t_byte q[$], input bit ends_string);
        foreach (q[i]) begin
            pace_sender();
            send_byte(q[i], ends_string && (i == q.size() - 1));
        end
    endtask

    task automatic send_text(input string s, input bit ends_string);
        t_byte q[$];
        foreach (s[i]) q.push_back(t_byte'(s[i]));
        send_bytes(q, ends_string);
    endtask

    // quiet input, all results back, then room for a flush still in flight
    task automatic settle_block();
        in_if.valid = 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (FLUSH_CYCLES) @(negedge i_clk);
    endtask

    // register write, only while the block is settled
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        case (idx)
            REG_SEP_BYTES: begin
                sep_pattern = data[SEP_BYTES_W-1:0];
                restart_string();
            end
            REG_SEP_LEN: begin
                sep_len_reg = data[SEP_LEN_W-1:0];
                restart_string();
            end
            REG_MAX_FIELDS: field_limit = data[MAX_FIELDS_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset separator: leading, repeated and trailing commas, empty string,
    // zero and all-ones bytes
    task automatic test_default_separator();
        send_text(",,a,,bc,", 1);
        send_text(",,", 1);
        send_bytes('{8'h00, 8'h2C, 8'hFF}, 1);
        settle_block();
    endtask

    // length 0 acts as 1, lengths above SEP_MAX as SEP_MAX, non-overlapping hits
    task automatic test_separator_length();
        write_reg(REG_SEP_LEN, 64'd0);
        send_text("a,b", 1);
        settle_block();
        write_reg(REG_SEP_BYTES, '1);
        write_reg(REG_SEP_LEN, 64'd15);
        // widest flush: seven pending bytes behind a non-match
        send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01}, 1);
        settle_block();
        write_reg(REG_SEP_BYTES, 64'h6161);
        write_reg(REG_SEP_LEN, 64'd2);
        send_text("aaab", 1);
        settle_block();
    endtask

    // field budget, including a change in the middle of a string
    task automatic test_field_limit();
        write_reg(REG_SEP_BYTES, 64'h2C);
        write_reg(REG_SEP_LEN, 64'd1);
        write_reg(REG_MAX_FIELDS, 64'd1);
        send_text("a,,b,c", 1);
        settle_block();
        write_reg(REG_MAX_FIELDS, 64'd0);
        send_text(",x,y", 1);
        settle_block();
        write_reg(REG_MAX_FIELDS, 64'hFFFF);
        send_text("p,q", 0);
        settle_block();
        write_reg(REG_MAX_FIELDS, 64'd1);
        send_text(",r", 1);
        settle_block();
        write_reg(REG_MAX_FIELDS, 64'hFFFF);
        settle_block();
    endtask

    // separator writes drop pending window bytes; unknown index is ignored
    task automatic test_config_restart();
        write_reg(REG_SEP_BYTES, 64'h3A3A);
        write_reg(REG_SEP_LEN, 64'd2);
        send_text("ab:", 0);
        settle_block();
        write_reg(REG_SEP_BYTES, 64'h2C);
        write_reg(REG_SEP_LEN, 64'd1);
        send_text("c", 1);
        settle_block();
        write_reg(REG_NONE, 64'h5);
        send_text("d,e", 1);
        settle_block();
    endtask

    // many fields in one string under the reset budget, back to back
    task automatic test_counter_limit();
        int unsigned n;
        sink_mode = SINK_OPEN;
        for (n = 0; n < 10; n++) begin
            send_byte(8'h61, 1'b0);
            send_byte(8'h2C, 1'b0);
        end
        send_text("b,c", 1);
        settle_block();
        sink_mode = SINK_PATTERN;
    endtask

    task automatic pick_random_setup();
        logic [63:0] pat;
        logic [63:0] word;
        int unsigned k;
        for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 3))
                0: pat[8*k +: 8] = 8'h2C;
                1: pat[8*k +: 8] = 8'h3B;
                2: pat[8*k +: 8] = 8'h61;
                default: pat[8*k +: 8] = 8'($urandom_range(1, 255));
            endcase
        end
        write_reg(REG_SEP_BYTES, pat);
        // junk above the register width must not matter
        word = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: word[3:0] = 4'd0;
            1: word[3:0] = 4'(SEP_MAX);
            2: word[3:0] = 4'($urandom_range(SEP_MAX + 1, 15));
            default: word[3:0] = 4'($urandom_range(1, 3));
        endcase
        write_reg(REG_SEP_LEN, word);
        word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: word[15:0] = 16'd0;
            1: word[15:0] = 16'($urandom_range(1, 2));
            2: word[15:0] = 16'($urandom_range(3, 6));
            default: word[15:0] = 16'hFFFF;
        endcase
        write_reg(REG_MAX_FIELDS, word);
        if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, {$urandom, $urandom});
    endtask

    // text mixed from whole and partial separators, separator bytes and noise
    task automatic send_random_string(input int unsigned max_len);
        t_byte       q[$];
        int unsigned len;
        int unsigned cut;
        int unsigned k;
        len = $urandom_range(1, max_len);
        while (q.size() < len) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    cut = ($urandom_range(0, 2) == 0) ?
                        $urandom_range(1, active_sep_len()) : active_sep_len();
                    for (k = 0; k < cut; k++) q.push_back(sep_pattern[8*k +: 8]);
                end
                2: q.push_back(sep_pattern[8*$urandom_range(0, active_sep_len() - 1) +: 8]);
                3: q.push_back(8'($urandom_range(1, 255)));
                default: q.push_back(8'h61 + 8'($urandom_range(0, 2)));
            endcase
        end
        send_bytes(q, 1);
    endtask

    task automatic test_random_strings();
        int unsigned first_item;
        int unsigned strings;
        first_item = items_sent;
        strings    = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            if (strings % 4 == 0) begin
                settle_block();
                pick_random_setup();
            end
            if (strings == 10) begin
                // receiver holds off while a long string keeps coming
                hold_requests++;
                burst_left = 80;
                send_random_string(60);
            end else begin
                send_random_string(($urandom_range(0, 7) == 0) ? 40 : 12);
            end
            strings++;
        end
        settle_block();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SEP_BYTES;
        cfg_wdata     = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        mismatches    = 0;
        items_sent    = 0;
        burst_left    = 0;
        hold_requests = 0;
        quiet_cycles  = 0;
        sink_mode     = SINK_PATTERN;
        sep_pattern   = SEP_BYTES_RST;
        sep_len_reg   = SEP_LEN_RST;
        field_limit   = MAX_FIELDS_RST;
        restart_string();

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_default_separator();
        test_separator_length();
        test_field_limit();
        test_config_restart();
        test_counter_limit();
        test_random_strings();

        settle_block();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/dfs_pkg.sv
src/dfs_stream_if.sv
src/dfs_window_cell.sv
src/dfs_out_buffer.sv
src/delimiter_field_splitter.sv
src/dfs_checker.sv
test/tb_delimiter_field_splitter.sv
